### sv/assert_macros.svh
// Assertion shorthands; expect clk and rst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check while out of reset.
`define LZ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check at every edge, reset included.
`define LZ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/lzwd_pkg.sv
package lzwd_pkg;

  localparam int BYTE_W   = 8;
  localparam int HDR_BITS = 24;
  localparam int LEN_W    = 5;

  localparam logic [LEN_W-1:0]  LEN_BIAS        = 5'd3;
  localparam logic [BYTE_W-1:0] FILL_BYTE       = 8'hFF;
  localparam logic [3:0]        TOKENS_PER_FLAG = 4'd8;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              run_last;
    logic              stream_end;
  } out_beat_t;

endpackage

### sv/lzwd_ram.sv
module lzwd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/lz_window_decompressor.sv
// Channel | Dir | tdata           | tlast    | tuser
// in_     | in  | [7:0] in_byte   | -        | [0] stream_start
// out_    | out | [7:0] out_byte  | run_last | [0] stream_end
//
// A reference is taken as its high byte, then its low byte, which starts a
// copy of len bytes with one history read per copied byte; len is 3 to 18.
// Reset and stream_start empty the history without a clearing pass: entries
// at or above the fill mark (write pointer, wrapped flag) read as 0xFF.
// A stalled output holds up to two beats (output register plus hold stage);
// copying pauses while both are full, and the input stalls until they drain.
module lz_window_decompressor #(
  parameter int WINDOW_BITS = 12,
  parameter int SIZE_BITS   = 24
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [lzwd_pkg::BYTE_W-1:0] in_tdata,   // [7:0] in_byte
  input  logic [0:0]                  in_tuser,   // [0] stream_start
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [lzwd_pkg::BYTE_W-1:0] out_tdata,  // [7:0] out_byte
  output logic                        out_tlast,  // run_last
  output logic [0:0]                  out_tuser   // [0] stream_end
);
  import lzwd_pkg::*;

  localparam int W = WINDOW_BITS;

  // decoder phases
  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_HEADER = 3'd1;
  localparam logic [2:0] PH_FLAG   = 3'd2;
  localparam logic [2:0] PH_TOKEN  = 3'd3;
  localparam logic [2:0] PH_REFLOW = 3'd4;
  localparam logic [2:0] PH_DONE   = 3'd5;
  localparam logic [2:0] PH_COPY   = 3'd6;

  localparam logic [SIZE_BITS-1:0] REM_ONE = SIZE_BITS'(1);

  // control state
  logic [2:0]           phase_r, phase_nxt;
  logic [1:0]           hpos_r, hpos_nxt;
  logic [SIZE_BITS-1:0] rem_r, rem_nxt;
  logic [7:0]           flag_r, flag_nxt;
  logic [3:0]           tok_r, tok_nxt;
  logic [W-1:0]         wp_r, wp_nxt;
  logic                 full_r, full_nxt;
  logic [LEN_W-1:0]     cnt_r, cnt_nxt;
  logic                 pend_r, pend_nxt;
  logic                 ov_r, ov_nxt;
  logic                 hv_r, hv_nxt;

  // payload
  logic [7:0]           refhi_r, refhi_nxt;
  logic [W-1:0]         src_r, src_nxt;
  logic                 pend_last_r, fwd_r, vld_r;
  logic [7:0]           fwd_data_r;
  out_beat_t            obeat_r, obeat_nxt, hbeat_r, hbeat_nxt;

  logic                 in_acc, out_take;
  logic                 lit_emit, emit, rem_one, issue;
  logic [7:0]           ram_q, rd_byte, emit_byte;
  out_beat_t            abeat;
  logic [1:0]           occ;
  logic [HDR_BITS-1:0]  hdr_word;
  logic [15:0]          code;
  logic [LEN_W-1:0]     ref_len;
  logic [W-1:0]         ref_dist;

  assign in_acc   = in_tvalid & in_tready;
  assign out_take = out_tvalid & out_tready;

  // take a beat only when no copy runs and the output has room for a literal
  assign in_tready = (phase_r != PH_COPY) && !pend_r && !hv_r && (!ov_r || out_tready);

  assign lit_emit = in_acc && !in_tuser[0] && (phase_r == PH_TOKEN) && !flag_r[7];
  assign emit     = lit_emit || pend_r;
  assign rem_one  = (rem_r == REM_ONE);

  // forwarded byte, stored byte, or the reset fill above the fill mark
  assign rd_byte   = fwd_r ? fwd_data_r : (vld_r ? ram_q : FILL_BYTE);
  assign emit_byte = lit_emit ? in_tdata : rd_byte;

  assign abeat.data       = emit_byte;
  assign abeat.run_last   = lit_emit ? 1'b1 : pend_last_r;
  assign abeat.stream_end = rem_one;

  // beats held or in flight once this cycle's take is done
  assign occ   = {1'b0, ov_r} + {1'b0, hv_r} + {1'b0, pend_r} - {1'b0, out_take};
  assign issue = (phase_r == PH_COPY) && (cnt_r != '0) && (occ <= 2'd1);

  assign hdr_word = HDR_BITS'(in_tdata) << {hpos_r - 2'd1, 3'b000};
  assign code     = {refhi_r, in_tdata};
  assign ref_len  = LEN_W'(code[15:12]) + LEN_BIAS;
  // distance wraps in the window, so a full-window distance lands on the pointer
  assign ref_dist = code[W-1:0] + W'(1);

  lzwd_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (1 << W)
  ) u_hist (
    .clk   (clk),
    .we    (emit),
    .waddr (wp_r),
    .wdata (emit_byte),
    .re    (issue),
    .raddr (src_r),
    .rdata (ram_q)
  );

  always_comb begin
    phase_nxt = phase_r;
    hpos_nxt  = hpos_r;
    rem_nxt   = rem_r;
    flag_nxt  = flag_r;
    tok_nxt   = tok_r;
    wp_nxt    = wp_r;
    full_nxt  = full_r;
    cnt_nxt   = cnt_r;
    refhi_nxt = refhi_r;
    src_nxt   = src_r;

    if (in_acc && in_tuser[0]) begin
      // new stream: drop all decoder state, history included
      phase_nxt = PH_HEADER;
      hpos_nxt  = 2'd1;
      rem_nxt   = '0;
      flag_nxt  = '0;
      tok_nxt   = '0;
      wp_nxt    = '0;
      full_nxt  = 1'b0;
      refhi_nxt = '0;
    end else if (in_acc) begin
      case (phase_r)
        PH_HEADER: begin
          rem_nxt  = rem_r | hdr_word[SIZE_BITS-1:0];
          hpos_nxt = hpos_r + 2'd1;
          if (hpos_r == 2'd3) begin
            phase_nxt = (rem_nxt == '0) ? PH_DONE : PH_FLAG;
          end
        end
        PH_FLAG: begin
          flag_nxt  = in_tdata;
          tok_nxt   = TOKENS_PER_FLAG;
          phase_nxt = PH_TOKEN;
        end
        PH_TOKEN: begin
          if (flag_r[7]) begin
            refhi_nxt = in_tdata;
            phase_nxt = PH_REFLOW;
          end else if (!rem_one) begin
            flag_nxt  = {flag_r[6:0], 1'b0};
            tok_nxt   = tok_r - 4'd1;
            phase_nxt = (tok_r == 4'd1) ? PH_FLAG : PH_TOKEN;
          end
        end
        PH_REFLOW: begin
          src_nxt   = wp_r - ref_dist;
          // clip the copy at the declared size
          cnt_nxt   = (rem_r < SIZE_BITS'(ref_len)) ? rem_r[LEN_W-1:0] : ref_len;
          phase_nxt = PH_COPY;
        end
        default: begin
        end
      endcase
    end

    if (issue) begin
      src_nxt = src_r + 1'b1;
      cnt_nxt = cnt_r - 1'b1;
    end

    // last copied byte closes the token
    if (pend_r && pend_last_r && !rem_one) begin
      flag_nxt  = {flag_r[6:0], 1'b0};
      tok_nxt   = tok_r - 4'd1;
      phase_nxt = (tok_r == 4'd1) ? PH_FLAG : PH_TOKEN;
    end

    if (emit) begin
      wp_nxt   = wp_r + 1'b1;
      full_nxt = full_r | (&wp_r);
      rem_nxt  = rem_r - REM_ONE;
      if (rem_one) begin
        phase_nxt = PH_DONE;
      end
    end
  end

  // output register with one hold stage behind it
  always_comb begin
    ov_nxt    = ov_r;
    hv_nxt    = hv_r;
    obeat_nxt = obeat_r;
    hbeat_nxt = hbeat_r;
    if (!ov_r || out_take) begin
      if (hv_r) begin
        obeat_nxt = hbeat_r;
        ov_nxt    = 1'b1;
        hv_nxt    = emit;
        hbeat_nxt = abeat;
      end else begin
        ov_nxt    = emit;
        obeat_nxt = abeat;
      end
    end else if (emit) begin
      hv_nxt    = 1'b1;
      hbeat_nxt = abeat;
    end
  end

  assign pend_nxt = issue;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      hpos_r  <= '0;
      rem_r   <= '0;
      flag_r  <= '0;
      tok_r   <= '0;
      wp_r    <= '0;
      full_r  <= 1'b0;
      cnt_r   <= '0;
      pend_r  <= 1'b0;
      ov_r    <= 1'b0;
      hv_r    <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      hpos_r  <= hpos_nxt;
      rem_r   <= rem_nxt;
      flag_r  <= flag_nxt;
      tok_r   <= tok_nxt;
      wp_r    <= wp_nxt;
      full_r  <= full_nxt;
      cnt_r   <= cnt_nxt;
      pend_r  <= pend_nxt;
      ov_r    <= ov_nxt;
      hv_r    <= hv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    refhi_r     <= refhi_nxt;
    src_r       <= src_nxt;
    obeat_r     <= obeat_nxt;
    hbeat_r     <= hbeat_nxt;
    // forward a byte written in the same cycle as its read
    pend_last_r <= (cnt_r == LEN_W'(1));
    fwd_r       <= emit && (src_r == wp_r);
    fwd_data_r  <= emit_byte;
    vld_r       <= full_r || (src_r < wp_r);
  end

  assign out_tvalid   = ov_r;
  assign out_tdata    = obeat_r.data;
  assign out_tlast    = obeat_r.run_last;
  assign out_tuser[0] = obeat_r.stream_end;

endmodule

### sv/lzwd_checker.sv
`include "assert_macros.svh"

module lzwd_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tvalid,
  input logic                        in_tready,
  input logic [lzwd_pkg::BYTE_W-1:0] in_tdata,
  input logic [0:0]                  in_tuser,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [lzwd_pkg::BYTE_W-1:0] out_tdata,
  input logic                        out_tlast,
  input logic [0:0]                  out_tuser
);
  import lzwd_pkg::*;

  logic              in_stall, out_stall, out_end;
  logic [BYTE_W:0]   in_pay;
  logic [BYTE_W+1:0] out_pay;

  assign in_stall  = in_tvalid && !in_tready;
  assign out_stall = out_tvalid && !out_tready;
  assign out_end   = out_tvalid && out_tready && out_tuser[0];
  assign in_pay    = {in_tuser, in_tdata};
  assign out_pay   = {out_tuser, out_tlast, out_tdata};

  // the size-completing byte always closes its run
  `LZ_ASSERT(a_end_is_last, out_tvalid && out_tuser[0] |-> out_tlast, "end beat not last")

  // nothing follows the size-completing beat at once
  `LZ_ASSERT(a_quiet_after_end, out_end |=> !out_tvalid, "beat right after stream end")

  // a stalled beat stays put
  `LZ_ASSERT(a_stall_hold, out_stall |=> out_tvalid && $stable(out_pay), "stalled beat changed")

  // a waiting input beat stays put
  `LZ_ASSERT(a_in_hold, in_stall |=> in_tvalid && $stable(in_pay), "stalled input changed")

  // reset empties the output side
  `LZ_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_tvalid, "output valid after reset")

endmodule

bind lz_window_decompressor lzwd_checker u_lzwd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
